[rtl/core/cle_pkg.sv]
package cle_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  // one extra bit so a step index reaches len + 1
  localparam int STEP_W    = ADDR_W + 1;
  localparam int CAP_W     = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [7:0] CH_CTRL_C = 8'd3;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_UPPER_C = 8'd67;
  localparam logic [7:0] CH_TILDE  = 8'd126;
  localparam logic [7:0] CH_DEL    = 8'd127;

  typedef enum logic [1:0] {
    CMD_PRINT,
    CMD_ERASE,
    CMD_CANCEL,
    CMD_NEWLINE
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

endpackage

[rtl/core/console_line_editor.sv]
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | in_rx_byte[7:0]
// out_    | output    | out_valid / out_stall| out_item_kind, out_data_byte, out_line_length,
//         |           |                      | out_cancelled, out_last
// cfg_    | input     | cfg_valid / cfg_ready| cfg_line_capacity[5:0]
//
// A byte is taken while idle; each of its n results then passes through the output register
// in turn. A line end walks the store one entry per cycle while out_stall is low, the read
// for the next step overlapping the current result. No result: idle at once.
// Reset (synchronous, rst_n low) clears the line length, restores capacity 32 and drops any
// pending result; the line store is not cleared.
// out_stall holds the output register and step index; in_stall is high until the last result.
module console_line_editor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_item_kind,
  output logic [7:0]                  out_data_byte,
  output logic [4:0]                  out_line_length,
  output logic                        out_cancelled,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cle_pkg::CAP_W-1:0]   cfg_line_capacity
);

  localparam int CMPW = cle_pkg::STEP_W + 1;

  logic [7:0] line_mem [cle_pkg::BUF_DEPTH];
  logic [7:0] rd_data_r;
  logic [cle_pkg::ADDR_W-1:0] rd_addr;

  cle_pkg::state_t state_r, state_nxt;
  cle_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [cle_pkg::CAP_W-1:0]  cap_r;
  logic [cle_pkg::ADDR_W-1:0] count_r, count_nxt;
  logic [cle_pkg::ADDR_W-1:0] len_r, len_nxt;
  logic [cle_pkg::STEP_W-1:0] idx_r, idx_nxt;
  logic [7:0] byte_r, byte_nxt;

  logic       out_valid_r;
  logic [1:0] kind_r;
  logic [7:0] data_r;
  logic [4:0] olen_r;
  logic       canc_r, last_r;

  logic       accept, out_free, emit;
  logic       is_print, has_room, has_result, wr_en;
  logic [CMPW-1:0] cap_eff, max_len;

  logic [1:0] e_kind;
  logic [7:0] e_data;
  logic [4:0] e_len;
  logic       e_canc, e_last;

  assign in_stall  = (state_r != cle_pkg::S_IDLE);
  assign cfg_ready = (state_r == cle_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r == cle_pkg::S_EMIT) && out_free;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(cap_r) > CMPW'(cle_pkg::BUF_DEPTH)) begin
      cap_eff = CMPW'(cle_pkg::BUF_DEPTH);
    end else begin
      cap_eff = CMPW'(cap_r);
    end
    max_len = cap_eff - CMPW'(1);
  end

  assign is_print = (in_rx_byte >= cle_pkg::CH_SPACE) && (in_rx_byte <= cle_pkg::CH_TILDE);
  assign has_room = (CMPW'(count_r) < max_len) &&
                    (CMPW'(count_r) < CMPW'(cle_pkg::BUF_DEPTH - 1));
  assign wr_en    = accept && is_print && has_room;

  // decode on accept; count moves right away, old length kept for the dump
  always_comb begin
    cmd_nxt    = cmd_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    byte_nxt   = byte_r;
    has_result = 1'b0;
    if (accept) begin
      byte_nxt = in_rx_byte;
      len_nxt  = count_r;
      if (in_rx_byte == cle_pkg::CH_CR || in_rx_byte == cle_pkg::CH_LF) begin
        cmd_nxt    = cle_pkg::CMD_NEWLINE;
        count_nxt  = '0;
        has_result = 1'b1;
      end else if (in_rx_byte == cle_pkg::CH_BS || in_rx_byte == cle_pkg::CH_DEL) begin
        cmd_nxt = cle_pkg::CMD_ERASE;
        if (count_r != '0) begin
          count_nxt  = count_r - 1'b1;
          has_result = 1'b1;
        end
      end else if (in_rx_byte == cle_pkg::CH_CTRL_C) begin
        cmd_nxt    = cle_pkg::CMD_CANCEL;
        count_nxt  = '0;
        has_result = 1'b1;
      end else if (is_print) begin
        cmd_nxt = cle_pkg::CMD_PRINT;
        if (has_room) begin
          count_nxt  = count_r + 1'b1;
          has_result = 1'b1;
        end
      end
    end
  end

  // result for the current step
  always_comb begin
    e_kind = cle_pkg::KIND_ECHO;
    e_data = '0;
    e_len  = '0;
    e_canc = 1'b0;
    e_last = 1'b0;
    case (cmd_r)
      cle_pkg::CMD_PRINT: begin
        e_data = byte_r;
        e_last = 1'b1;
      end
      cle_pkg::CMD_ERASE: begin
        e_data = (idx_r == cle_pkg::STEP_W'(1)) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
        e_last = (idx_r == cle_pkg::STEP_W'(2));
      end
      cle_pkg::CMD_CANCEL: begin
        if (idx_r == cle_pkg::STEP_W'(0)) begin
          e_data = cle_pkg::CH_CARET;
        end else if (idx_r == cle_pkg::STEP_W'(1)) begin
          e_data = cle_pkg::CH_UPPER_C;
        end else if (idx_r == cle_pkg::STEP_W'(2)) begin
          e_data = cle_pkg::CH_LF;
        end else begin
          e_kind = cle_pkg::KIND_END;
          e_canc = 1'b1;
          e_last = 1'b1;
        end
      end
      default: begin
        if (idx_r == cle_pkg::STEP_W'(0)) begin
          e_data = cle_pkg::CH_LF;
        end else if (idx_r == cle_pkg::STEP_W'(len_r) + 1'b1) begin
          e_kind = cle_pkg::KIND_END;
          e_len  = 5'(len_r);
          e_last = 1'b1;
        end else begin
          e_kind = cle_pkg::KIND_LINE;
          e_data = rd_data_r;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      cle_pkg::S_IDLE: begin
        idx_nxt = '0;
        if (accept && has_result) begin
          state_nxt = cle_pkg::S_EMIT;
        end
      end
      cle_pkg::S_EMIT: begin
        if (emit) begin
          idx_nxt = idx_r + 1'b1;
          if (e_last) begin
            state_nxt = cle_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = cle_pkg::S_IDLE;
      end
    endcase
  end

  // fetch the byte the next step needs; writes only happen at accept, before any dump read
  assign rd_addr = cle_pkg::ADDR_W'(idx_nxt - 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[count_r] <= in_rx_byte;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cle_pkg::S_IDLE;
      cap_r       <= cle_pkg::CAP_RESET;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_line_capacity;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    len_r  <= len_nxt;
    byte_r <= byte_nxt;
    if (emit) begin
      kind_r <= e_kind;
      data_r <= e_data;
      olen_r <= e_len;
      canc_r <= e_canc;
      last_r <= e_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_item_kind   = kind_r;
  assign out_data_byte   = data_r;
  assign out_line_length = olen_r;
  assign out_cancelled   = canc_r;
  assign out_last        = last_r;

  a_dump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cle_pkg::S_EMIT && cmd_r == cle_pkg::CMD_NEWLINE)
      |-> (idx_r <= cle_pkg::STEP_W'(len_r) + 1'b1))
    else $error("dump step past line end");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= CMPW'(cle_pkg::BUF_DEPTH - 1))
    else $error("line length beyond store");

  a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (count_r == $past(count_r) + 1'b1))
    else $error("stored byte did not advance length");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_last) |=> (state_r == cle_pkg::S_IDLE && out_valid_r && last_r))
    else $error("final result did not end the transaction");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cle_pkg::S_IDLE && !(accept && has_result)) |=> !emit)
    else $error("result produced without an accepted byte");

endmodule

[verif/console_line_editor_tb.sv]
module console_line_editor_tb;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [4:0] len;
    logic       cancelled;
    logic       last;
  } editor_item_t;

  // Shadow of the line editor: keeps its own line, length and capacity and
  // queues the echo, line and line-end transactions each byte should produce.
  class line_editor_board;
    editor_item_t pending_results[$];
    logic [7:0]   line_bytes [cle_pkg::BUF_DEPTH];
    int           held;
    int           capacity;
    int           fail_count;

    function new();
      held = 0;
      capacity = int'(cle_pkg::CAP_RESET);
      fail_count = 0;
    endfunction

    function void set_capacity(int cap);
      capacity = cap;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // Returns how many results the byte causes.
    function int note_byte(logic [7:0] rx);
      editor_item_t step_items[$];
      editor_item_t tail;
      int           room;
      if (rx == cle_pkg::CH_CR || rx == cle_pkg::CH_LF) begin
        step_items.push_back('{cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 5'd0, 1'b0, 1'b0});
        for (int i = 0; i < held; i++)
          step_items.push_back('{cle_pkg::KIND_LINE, line_bytes[i], 5'd0, 1'b0, 1'b0});
        step_items.push_back('{cle_pkg::KIND_END, 8'd0, 5'(held), 1'b0, 1'b0});
        held = 0;
      end else if (rx == cle_pkg::CH_BS || rx == cle_pkg::CH_DEL) begin
        if (held != 0) begin
          held--;
          step_items.push_back('{cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 5'd0, 1'b0, 1'b0});
          step_items.push_back('{cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, 5'd0, 1'b0, 1'b0});
          step_items.push_back('{cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 5'd0, 1'b0, 1'b0});
        end
      end else if (rx == cle_pkg::CH_CTRL_C) begin
        step_items.push_back('{cle_pkg::KIND_ECHO, cle_pkg::CH_CARET, 5'd0, 1'b0, 1'b0});
        step_items.push_back('{cle_pkg::KIND_ECHO, cle_pkg::CH_UPPER_C, 5'd0, 1'b0, 1'b0});
        step_items.push_back('{cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 5'd0, 1'b0, 1'b0});
        step_items.push_back('{cle_pkg::KIND_END, 8'd0, 5'd0, 1'b1, 1'b0});
        held = 0;
      end else if (rx >= cle_pkg::CH_SPACE && rx <= cle_pkg::CH_TILDE) begin
        // capacity counts the terminator, so one slot less is usable
        room = (capacity == 0) ? 1 :
               ((capacity > cle_pkg::BUF_DEPTH) ? cle_pkg::BUF_DEPTH : capacity);
        if (held < room - 1 && held < cle_pkg::BUF_DEPTH - 1) begin
          line_bytes[held] = rx;
          held++;
          step_items.push_back('{cle_pkg::KIND_ECHO, rx, 5'd0, 1'b0, 1'b0});
        end
      end
      if (step_items.size() != 0) begin
        tail = step_items.pop_back();
        tail.last = 1'b1;
        step_items.push_back(tail);
      end
      foreach (step_items[i]) pending_results.push_back(step_items[i]);
      return step_items.size();
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(editor_item_t got);
      editor_item_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: kind %0d data %0d length %0d", got.kind, got.data,
               got.len);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("item_kind", want.kind, got.kind);
      compare_field("data_byte", want.data, got.data);
      compare_field("line_length", want.len, got.len);
      compare_field("cancelled", want.cancelled, got.cancelled);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                in_rx_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic [1:0]                out_item_kind;
  logic [7:0]                out_data_byte;
  logic [4:0]                out_line_length;
  logic                      out_cancelled;
  logic                      out_last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [cle_pkg::CAP_W-1:0] cfg_line_capacity;

  line_editor_board board;
  bit               no_gaps;
  int               stall_left;
  int               sent_bytes;

  console_line_editor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_kind     (out_item_kind),
    .out_data_byte     (out_data_byte),
    .out_line_length   (out_line_length),
    .out_cancelled     (out_cancelled),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_line_capacity (cfg_line_capacity)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous fixed bound, well above the slowest legal run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver back-pressure, changed on the falling edge.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result('{out_item_kind, out_data_byte, out_line_length, out_cancelled,
                           out_last});
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    void'(board.note_byte(b));
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    in_valid = 1'b0;
    while (board.pending_count() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input int cap);
    wait_results_done();
    // a byte with no result may still be in flight
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_line_capacity = cle_pkg::CAP_W'(cap);
    do @(posedge clk); while (!cfg_ready);
    board.set_capacity(cap);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(cle_pkg::CH_SPACE, cle_pkg::CH_TILDE));
  endfunction

  // Mostly well-formed typing: printable text with some erasing, a little noise,
  // closed by a newline or a Ctrl-C.
  task automatic type_line();
    int n;
    int r;
    n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 20) : $urandom_range(21, 40);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 78) send_byte(printable());
      else if (r < 88) send_byte($urandom_range(0, 1) ? cle_pkg::CH_BS : cle_pkg::CH_DEL);
      else if (r < 94) send_byte(8'($urandom_range(0, 255)));
      else send_byte(printable());
    end
    r = $urandom_range(0, 99);
    if (r < 40) send_byte(cle_pkg::CH_CR);
    else if (r < 80) send_byte(cle_pkg::CH_LF);
    else send_byte(cle_pkg::CH_CTRL_C);
  endtask

  initial begin
    int phase_cap [5];
    int start;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'd0;
    cfg_valid = 1'b0;
    cfg_line_capacity = cle_pkg::CAP_RESET;
    no_gaps = 1'b0;
    sent_bytes = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed: printable extremes, erase, both line ends, empty erase, cancel, noise
    send_byte(cle_pkg::CH_SPACE);
    send_byte(cle_pkg::CH_TILDE);
    send_byte(8'd120);
    send_byte(cle_pkg::CH_BS);
    send_byte(cle_pkg::CH_DEL);
    send_byte(cle_pkg::CH_CR);
    send_byte(cle_pkg::CH_BS);
    send_byte(cle_pkg::CH_LF);
    send_byte(cle_pkg::CH_CTRL_C);
    send_byte(8'd0);
    send_byte(8'd255);
    send_byte(8'd31);
    send_byte(8'd128);
    // capacity lowered below what the line already holds
    send_byte(8'd97);
    send_byte(8'd98);
    send_byte(8'd99);
    send_byte(8'd100);
    write_capacity(2);
    send_byte(8'd101);
    send_byte(cle_pkg::CH_CR);
    write_capacity(1);
    send_byte(8'd122);
    send_byte(cle_pkg::CH_BS);
    send_byte(cle_pkg::CH_CR);
    write_capacity(3);
    send_byte(8'd112);
    send_byte(8'd113);
    send_byte(8'd114);
    send_byte(cle_pkg::CH_LF);

    phase_cap[0] = 32;
    phase_cap[1] = $urandom_range(2, 8);
    phase_cap[2] = 1;
    phase_cap[3] = 31;
    phase_cap[4] = $urandom_range(9, 30);
    for (int p = 0; p < 5; p++) begin
      write_capacity(phase_cap[p]);
      no_gaps = (p == 3);
      start = sent_bytes;
      while (sent_bytes - start < 20) begin
        type_line();
        if ($urandom_range(0, 7) == 0) wait_results_done();
      end
    end
    no_gaps = 1'b0;

    wait_results_done();
    repeat (10) @(posedge clk);
    if (board.fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
